### rtl/core/encoder_tuned_dds_square_generator_assert.svh
// Assertion helpers shared by the generator RTL.
`ifndef ENCODER_TUNED_DDS_SQUARE_GENERATOR_ASSERT_SVH
`define ENCODER_TUNED_DDS_SQUARE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EDSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EDSQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/edsq_pkg.sv
`default_nettype none

package edsq_pkg;

  localparam int FREQ_W = 13;
  localparam int MOD_W  = 31;
  localparam int GAIN_W = 16;
  localparam int INC_W  = 30;
  localparam int CNT_W  = 2;

  // operation codes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register indexes (word address)
  localparam logic [2:0] REG_ACCUM_MODULUS = 3'd0;
  localparam logic [2:0] REG_FREQ_GAIN     = 3'd1;
  localparam logic [2:0] REG_FREQ_STEP     = 3'd2;
  localparam logic [2:0] REG_FREQ_UPPER    = 3'd3;
  localparam logic [2:0] REG_FREQ_LOWER    = 3'd4;

  localparam logic [MOD_W-1:0]  RST_ACCUM_MODULUS = 31'd1875000000;
  localparam logic [GAIN_W-1:0] RST_FREQ_GAIN     = 16'd60000;
  localparam logic [FREQ_W-1:0] RST_FREQ_STEP     = 13'd100;
  localparam logic [FREQ_W-1:0] RST_FREQ_UPPER    = 13'd5000;
  localparam logic [FREQ_W-1:0] RST_FREQ_LOWER    = 13'd100;

  localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;
  localparam logic [CNT_W-1:0] CNT_ONE = 2'd1;

  typedef struct packed {
    logic [MOD_W-1:0]  accum_modulus;
    logic [GAIN_W-1:0] freq_gain;
    logic [FREQ_W-1:0] freq_step;
    logic [FREQ_W-1:0] freq_upper;
    logic [FREQ_W-1:0] freq_lower;
  } cfg_t;

  // packed with wave_level in bit 0, as on the output bus
  typedef struct packed {
    logic [FREQ_W-1:0] frequency_now;
    logic              toggled;
    logic              wave_level;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/encoder_tuned_dds_square_generator.sv
`default_nettype none
// An accepted transaction's result is registered in the output register or skid entry.
// Throughput: one transaction per clock while s_tready is high; the accumulator
// add/compare/subtract and the frequency-times-gain multiply finish in the accepting cycle.
// A two-entry output buffer keeps s_tready high during a stall until the skid entry fills.
// Synchronous active-high rst: clears accumulator, frequency, counters and wave level,
// empties the output buffer and restores the register defaults.

module encoder_tuned_dds_square_generator #(
  parameter int ACCUM_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  // stream in
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [0] right_active, [1] left_active, [7:2] zero
  input  wire         s_tuser,   // [0] operation
  // stream out
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // [0] wave_level, [1] toggled, [14:2] frequency_now, [15] zero
  // register port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "encoder_tuned_dds_square_generator_assert.svh"

  edsq_pkg::cfg_t    cfg;
  edsq_pkg::result_t res;
  edsq_pkg::result_t out_data;
  edsq_pkg::result_t skid_data;
  logic              skid_valid;
  logic              accept;
  logic              cfg_write;
  logic [2:0]        reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accum_modulus <= edsq_pkg::RST_ACCUM_MODULUS;
      cfg.freq_gain     <= edsq_pkg::RST_FREQ_GAIN;
      cfg.freq_step     <= edsq_pkg::RST_FREQ_STEP;
      cfg.freq_upper    <= edsq_pkg::RST_FREQ_UPPER;
      cfg.freq_lower    <= edsq_pkg::RST_FREQ_LOWER;
    end else if (cfg_write) begin
      unique case (reg_index)
        edsq_pkg::REG_ACCUM_MODULUS: cfg.accum_modulus <= pwdata[edsq_pkg::MOD_W-1:0];
        edsq_pkg::REG_FREQ_GAIN:     cfg.freq_gain     <= pwdata[edsq_pkg::GAIN_W-1:0];
        edsq_pkg::REG_FREQ_STEP:     cfg.freq_step     <= pwdata[edsq_pkg::FREQ_W-1:0];
        edsq_pkg::REG_FREQ_UPPER:    cfg.freq_upper    <= pwdata[edsq_pkg::FREQ_W-1:0];
        edsq_pkg::REG_FREQ_LOWER:    cfg.freq_lower    <= pwdata[edsq_pkg::FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      edsq_pkg::REG_ACCUM_MODULUS: prdata = {1'b0, cfg.accum_modulus};
      edsq_pkg::REG_FREQ_GAIN:     prdata = {16'd0, cfg.freq_gain};
      edsq_pkg::REG_FREQ_STEP:     prdata = {19'd0, cfg.freq_step};
      edsq_pkg::REG_FREQ_UPPER:    prdata = {19'd0, cfg.freq_upper};
      edsq_pkg::REG_FREQ_LOWER:    prdata = {19'd0, cfg.freq_lower};
      default:                     prdata = '0;
    endcase
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  edsq_core #(
    .ACCUM_BITS(ACCUM_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .operation    (s_tuser),
    .right_active (s_tdata[0]),
    .left_active  (s_tdata[1]),
    .cfg          (cfg),
    .result       (res)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= res;
      end
    end else if (accept) begin
      skid_data <= res;
    end
  end

  assign m_tdata = {1'b0, out_data};

  `EDSQ_ASSERT_IMP(a_skid_behind_out, skid_valid, m_tvalid,
    "skid entry held while output register is empty")
  `EDSQ_ASSERT_NXT(a_stall_fills_skid, m_tvalid && !m_tready && accept,
    skid_valid && m_tvalid, "transaction accepted during stall was not buffered")
  `EDSQ_ASSERT_NXT(a_drain_skid, skid_valid && m_tready, !skid_valid && m_tvalid,
    "skid entry not moved to output when drained")

endmodule

`default_nettype wire

### rtl/core/edsq_core.sv
`default_nettype none

module edsq_core #(
  parameter int ACCUM_BITS = 32
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  input  wire                    operation,
  input  wire                    right_active,
  input  wire                    left_active,
  input  wire edsq_pkg::cfg_t    cfg,
  output edsq_pkg::result_t      result
);

  `include "encoder_tuned_dds_square_generator_assert.svh"

  localparam int CMP_W = (ACCUM_BITS > edsq_pkg::MOD_W) ? ACCUM_BITS : edsq_pkg::MOD_W;
  localparam int PROD_W = edsq_pkg::FREQ_W + edsq_pkg::GAIN_W;

  logic [ACCUM_BITS-1:0]         phase_accum;
  logic [ACCUM_BITS-1:0]         phase_accum_next;
  logic [edsq_pkg::INC_W-1:0]    phase_increment;
  logic [edsq_pkg::INC_W-1:0]    phase_increment_next;
  logic [edsq_pkg::FREQ_W-1:0]   frequency_setting;
  logic [edsq_pkg::FREQ_W-1:0]   frequency_setting_next;
  logic [edsq_pkg::CNT_W-1:0]    right_count;
  logic [edsq_pkg::CNT_W-1:0]    right_count_next;
  logic [edsq_pkg::CNT_W-1:0]    left_count;
  logic [edsq_pkg::CNT_W-1:0]    left_count_next;
  logic                          wave_bit;
  logic                          wave_bit_next;

  logic [CMP_W-1:0]              sum_wide;
  logic [ACCUM_BITS-1:0]         sum;
  logic [CMP_W-1:0]              diff_wide;
  logic                          wrap;
  logic [edsq_pkg::CNT_W-1:0]    r_cnt;
  logic [edsq_pkg::CNT_W-1:0]    l_cnt;
  logic [edsq_pkg::FREQ_W:0]     up_sum;
  logic [edsq_pkg::FREQ_W:0]     low_sum;
  logic [edsq_pkg::FREQ_W-1:0]   freq_new;
  logic                          freq_change;
  logic [PROD_W-1:0]             product;

  // tick path: one add, one compare, one subtract
  always_comb begin
    sum_wide  = CMP_W'(phase_accum) + CMP_W'(phase_increment);
    sum       = sum_wide[ACCUM_BITS-1:0];
    wrap      = CMP_W'(sum) >= CMP_W'(cfg.accum_modulus);
    diff_wide = CMP_W'(sum) - CMP_W'(cfg.accum_modulus);
  end

  // encoder path
  always_comb begin
    r_cnt       = right_count;
    l_cnt       = left_count;
    freq_new    = frequency_setting;
    freq_change = 1'b0;
    up_sum      = {1'b0, frequency_setting} + {1'b0, cfg.freq_step};
    low_sum     = {1'b0, cfg.freq_lower} + {1'b0, cfg.freq_step};

    if (right_active) begin
      r_cnt = '0;
    end else if (right_count < edsq_pkg::CNT_MAX) begin
      r_cnt = right_count + 1'b1;
    end

    if (r_cnt == edsq_pkg::CNT_ONE && left_active) begin
      // step up; left counter untouched on this sample
      if (up_sum <= {1'b0, cfg.freq_upper}) begin
        freq_new    = up_sum[edsq_pkg::FREQ_W-1:0];
        freq_change = 1'b1;
      end
    end else begin
      if (left_active) begin
        l_cnt = '0;
      end else if (left_count < edsq_pkg::CNT_MAX) begin
        l_cnt = left_count + 1'b1;
      end
      if (l_cnt == edsq_pkg::CNT_ONE && right_active &&
          {1'b0, frequency_setting} >= low_sum) begin
        freq_new    = frequency_setting - cfg.freq_step;
        freq_change = 1'b1;
      end
    end

    product = PROD_W'(freq_new) * PROD_W'(cfg.freq_gain);
  end

  always_comb begin
    phase_accum_next       = phase_accum;
    phase_increment_next   = phase_increment;
    frequency_setting_next = frequency_setting;
    right_count_next       = right_count;
    left_count_next        = left_count;
    wave_bit_next          = wave_bit;
    result.toggled         = 1'b0;

    if (in_valid) begin
      if (operation == edsq_pkg::OP_TICK) begin
        if (wrap) begin
          phase_accum_next = diff_wide[ACCUM_BITS-1:0];
          wave_bit_next    = ~wave_bit;
          result.toggled   = 1'b1;
        end else begin
          phase_accum_next = sum;
        end
      end else begin
        right_count_next       = r_cnt;
        left_count_next        = l_cnt;
        frequency_setting_next = freq_new;
        if (freq_change) begin
          phase_increment_next = edsq_pkg::INC_W'(product);
        end
      end
    end

    result.wave_level    = wave_bit_next;
    result.frequency_now = frequency_setting_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accum       <= '0;
      phase_increment   <= '0;
      frequency_setting <= '0;
      right_count       <= '0;
      left_count        <= '0;
      wave_bit          <= 1'b0;
    end else begin
      phase_accum       <= phase_accum_next;
      phase_increment   <= phase_increment_next;
      frequency_setting <= frequency_setting_next;
      right_count       <= right_count_next;
      left_count        <= left_count_next;
      wave_bit          <= wave_bit_next;
    end
  end

  `EDSQ_ASSERT_NXT(a_sample_keeps_phase,
    !rst && in_valid && operation == edsq_pkg::OP_SAMPLE, $stable(phase_accum),
    "phase accumulator moved on an encoder sample")
  `EDSQ_ASSERT_NXT(a_tick_keeps_freq,
    !rst && in_valid && operation == edsq_pkg::OP_TICK, $stable(frequency_setting),
    "frequency changed on a tick")
  `EDSQ_ASSERT_IMP(a_toggle_on_tick, result.toggled,
    in_valid && operation == edsq_pkg::OP_TICK && result.wave_level != wave_bit,
    "toggle flag without a tick that flips the level")

endmodule

`default_nettype wire
